### src/bre_pkg.sv
// ----------------------------------------------------------------------------
// bre_pkg: shared types and codes for the RLE8 decoder
// Result word layout and the escape codes of the coded stream.
// ----------------------------------------------------------------------------
`default_nettype none

package bre_pkg;

    localparam int BYTE_W = 8;

    // second byte of an escape pair
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    // delta escape carries two offset bytes
    localparam logic [1:0] DELTA_BYTES = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] count;
        logic              eob;
    } t_result;

endpackage

`default_nettype wire

### src/bre_decode.sv
// ----------------------------------------------------------------------------
// bre_decode: RLE8 stream state and per-byte decode
// Holds the parse state and turns one coded byte into zero or one result.
// ----------------------------------------------------------------------------
`default_nettype none

module bre_decode (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_fire,
    input  wire logic [bre_pkg::BYTE_W-1:0] i_byte,
    output bre_pkg::t_result               o_res
);
    import bre_pkg::*;

    typedef enum logic [2:0] {
        PH_COUNT   = 3'd0,
        PH_VALUE   = 3'd1,
        PH_ESCAPE  = 3'd2,
        PH_SKIP    = 3'd3,
        PH_LITERAL = 3'd4,
        PH_PAD     = 3'd5
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_pending, n_pending;
    logic [BYTE_W-1:0] r_lit_left, n_lit_left;
    logic              r_pad, n_pad;
    logic [1:0]        r_skip, n_skip;

    always_comb begin
        n_phase    = r_phase;
        n_pending  = r_pending;
        n_lit_left = r_lit_left;
        n_pad      = r_pad;
        n_skip     = r_skip;
        o_res      = '0;

        unique case (r_phase)
            PH_VALUE: begin
                o_res.valid = 1'b1;
                o_res.value = i_byte;
                o_res.count = r_pending;
                n_pending   = '0;
                n_phase     = PH_COUNT;
            end
            PH_ESCAPE: begin
                if (i_byte == ESC_EOB) begin
                    // end of bitmap: report and return to reset state
                    o_res.valid = 1'b1;
                    o_res.eob   = 1'b1;
                    n_phase     = PH_COUNT;
                    n_pending   = '0;
                    n_lit_left  = '0;
                    n_pad       = 1'b0;
                    n_skip      = '0;
                end else if (i_byte == ESC_DELTA) begin
                    n_skip  = DELTA_BYTES;
                    n_phase = PH_SKIP;
                end else if (i_byte == ESC_EOL) begin
                    n_phase = PH_COUNT;
                end else begin
                    n_lit_left = i_byte;
                    n_pad      = i_byte[0];
                    n_phase    = PH_LITERAL;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 2'd1;
                if (n_skip == 2'd0) begin
                    n_phase = PH_COUNT;
                end
            end
            PH_LITERAL: begin
                o_res.valid = 1'b1;
                o_res.value = i_byte;
                o_res.count = BYTE_W'(1);
                n_lit_left  = r_lit_left - BYTE_W'(1);
                if (n_lit_left == '0) begin
                    n_phase = r_pad ? PH_PAD : PH_COUNT;
                    n_pad   = 1'b0;
                end
            end
            PH_PAD: begin
                n_phase = PH_COUNT;
            end
            default: begin
                // count byte, also taken for unused phase codes
                if (i_byte != '0) begin
                    n_pending = i_byte;
                    n_phase   = PH_VALUE;
                end else begin
                    n_phase = PH_ESCAPE;
                end
            end
        endcase

        if (!i_fire) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_COUNT;
            r_pending  <= '0;
            r_lit_left <= '0;
            r_pad      <= 1'b0;
            r_skip     <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_pending  <= n_pending;
            r_lit_left <= n_lit_left;
            r_pad      <= n_pad;
            r_skip     <= n_skip;
        end
    end

endmodule

`default_nettype wire

### src/bmp_rle8_decoder_unit.sv
// ----------------------------------------------------------------------------
// bmp_rle8_decoder_unit: RLE8 coded byte stream to pixel runs
// Path: an accepted byte is held in the input register, decoded, and its result registered in the result register.
// Throughput: one coded byte per cycle unless the output side stalls; the decode step is combinational.
// Reset: synchronous, active low; clears both stage valids and parse state.
// Stall from the output side reaches the input stall in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_rle8_decoder_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [bre_pkg::BYTE_W-1:0] i_in_byte,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [bre_pkg::BYTE_W-1:0]      o_pixel_value,
    output logic [bre_pkg::BYTE_W-1:0]      o_repeat_count,
    output logic                            o_end_of_bitmap
);
    import bre_pkg::*;

    // input register stage
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;

    // result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_value;
    logic [BYTE_W-1:0] r_out_count;
    logic              r_out_eob;

    logic    out_free;   // result register can take a new word this cycle
    logic    s1_fire;    // held byte is decoded and retired this cycle
    logic    in_fire;
    t_result dec_res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    // held byte blocks the input only while it cannot move on
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    bre_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_byte  (r_s1_byte),
        .o_res   (dec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            // bytes that give no result leave the register empty
            r_out_valid <= s1_fire && dec_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_fire && dec_res.valid) begin
            r_out_value <= dec_res.value;
            r_out_count <= dec_res.count;
            r_out_eob   <= dec_res.eob;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_value   = r_out_value;
    assign o_repeat_count  = r_out_count;
    assign o_end_of_bitmap = r_out_eob;

    // end word carries zero value and count
    a_eob_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eob) |-> (r_out_value == '0 && r_out_count == '0))
        else $error("end word with nonzero payload");

    // a run word always carries a nonzero count
    a_run_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_eob) |-> (r_out_count != '0))
        else $error("run word with zero count");

    // a word held against stall is not dropped
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result word lost");

    // input is never stalled while output side is free
    a_no_bubble : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without downstream stall");

endmodule

`default_nettype wire
